// ===== hw/rtl/adsr_ts_pkg.sv =====
// ============================================================================
// adsr_ts_pkg: shared types and constants for the ADSR tone segmenter
// Field widths, register reset values, register map and divider request types.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package adsr_ts_pkg;

    // payload widths
    localparam int FREQ_W  = 16;
    localparam int LEN_W   = 16;
    localparam int AMP_W   = 12;

    // configuration register widths
    localparam int VOL_W   = 7;
    localparam int RAMP_W  = 8;
    localparam int PCT_W   = 7;

    // internal widths
    localparam int MS_W    = 9;   // ramp length, short notes reach 161 ms
    localparam int SUM_W   = 10;  // attack + decay + release, at most 480
    localparam int STEPS_W = 5;   // at most 20 steps per ramp
    localparam int DUR_W   = 4;   // step duration is at most 15 ms
    localparam int NUM_W   = 16;  // ramp numerator, at most 2500 * 20
    localparam int STEP_SHIFT = 3;

    // serial divider
    localparam int DIV_NW  = 18;  // dividend and quotient, peak * pct fits
    localparam int DIV_DW  = 7;   // divisor, at most 100
    localparam int DIV_CW  = 5;

    // apb port
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // limits and arithmetic constants
    localparam logic [VOL_W-1:0]  PCT_MAX    = 7'd100;
    localparam logic [RAMP_W-1:0] RAMP_MAX   = 8'd160;
    localparam logic [AMP_W-1:0]  AMP_BASE   = 12'd300;
    localparam logic [AMP_W-1:0]  AMP_SLOPE  = 12'd22;
    localparam logic [AMP_W-1:0]  AMP_MAX    = 12'd2500;
    localparam logic [DIV_DW-1:0] DIV_THIRD  = 7'd3;
    localparam logic [DIV_DW-1:0] DIV_PCT    = 7'd100;

    // register reset values
    localparam logic [VOL_W-1:0]  VOL_RST     = 7'd50;
    localparam logic [RAMP_W-1:0] ATTACK_RST  = 8'd10;
    localparam logic [RAMP_W-1:0] DECAY_RST   = 8'd50;
    localparam logic [PCT_W-1:0]  SUSTAIN_RST = 7'd70;
    localparam logic [RAMP_W-1:0] RELEASE_RST = 8'd50;

    // register map, word index
    typedef enum logic [2:0] {
        REG_VOLUME  = 3'd0,
        REG_ATTACK  = 3'd1,
        REG_DECAY   = 3'd2,
        REG_SUSTAIN = 3'd3,
        REG_RELEASE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [VOL_W-1:0]  volume;
        logic [RAMP_W-1:0] attack_ms;
        logic [RAMP_W-1:0] decay_ms;
        logic [PCT_W-1:0]  sustain_pct;
        logic [RAMP_W-1:0] release_ms;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/adsr_ts_note_if.sv =====
// ============================================================================
// adsr_ts_note_if: note request channel
// Valid/ready channel that carries one note (frequency, duration).
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface adsr_ts_note_if
    import adsr_ts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] note_freq_hz;
    logic [LEN_W-1:0]  note_len_ms;

    modport source (output valid, output note_freq_hz, output note_len_ms, input ready);
    modport sink   (input valid, input note_freq_hz, input note_len_ms, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adsr_ts_tone_if.sv =====
// ============================================================================
// adsr_ts_tone_if: tone command channel
// Valid/ready channel that carries one constant-amplitude tone command.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface adsr_ts_tone_if
    import adsr_ts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] tone_freq_hz;
    logic [LEN_W-1:0]  tone_len_ms;
    logic [AMP_W-1:0]  tone_amplitude;
    logic              last_of_note;

    modport source (output valid, output tone_freq_hz, output tone_len_ms,
                    output tone_amplitude, output last_of_note, input ready);
    modport sink   (input valid, input tone_freq_hz, input tone_len_ms,
                    input tone_amplitude, input last_of_note, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adsr_tone_segmenter_core.sv =====
// Sequence: for each accepted note request the peak level, the sustain level and, on a short
//   note, the third of its length are computed before the first ramp command; every quotient
//   goes through the shared 18-step serial divider. One note is handled at a time; the longest
//   run is 61 commands, and output stalls hold the run. A silent note is taken in idle and
//   gives no command.
// Reset: synchronous active-low; sequencer idles, registers return to defaults.
// ============================================================================
// adsr_tone_segmenter_core: ADSR envelope as a run of constant-amplitude tones
// Sequencer that splits one note into attack, decay, sustain and release
// tone commands, driving a shared serial divider for every quotient.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module adsr_tone_segmenter_core
    import adsr_ts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    adsr_ts_note_if.sink           i_note,
    adsr_ts_tone_if.source         o_tone,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PEAK  = 12'b0000_0000_0010,
        S_SUSQ  = 12'b0000_0000_0100,
        S_SUSW  = 12'b0000_0000_1000,
        S_LEN   = 12'b0000_0001_0000,
        S_THIRD = 12'b0000_0010_0000,
        S_SEG   = 12'b0000_0100_0000,
        S_DUR   = 12'b0000_1000_0000,
        S_MUL   = 12'b0001_0000_0000,
        S_STEP  = 12'b0010_0000_0000,
        S_AMP   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [3:0] {
        PH_ATK = 4'b0001,
        PH_DEC = 4'b0010,
        PH_SUS = 4'b0100,
        PH_REL = 4'b1000
    } t_phase;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    t_state               r_state;
    t_phase               r_phase;
    logic [FREQ_W-1:0]    r_freq;
    logic [LEN_W-1:0]     r_len;
    logic [AMP_W-1:0]     r_peak;
    logic [AMP_W-1:0]     r_sus;
    logic [MS_W-1:0]      r_a;
    logic [MS_W-1:0]      r_d;
    logic [MS_W-1:0]      r_r;
    logic [LEN_W-1:0]     r_sus_ms;
    logic [STEPS_W-1:0]   r_steps;
    logic [STEPS_W-1:0]   r_i;
    logic [DUR_W-1:0]     r_dur;
    logic [NUM_W-1:0]     r_num;
    logic [AMP_W-1:0]     r_out_amp;
    logic [LEN_W-1:0]     r_out_len;
    logic                 r_out_last;

    logic [VOL_W-1:0]     vol_c;
    logic [PCT_W-1:0]     pct_c;
    logic [RAMP_W-1:0]    att_c;
    logic [RAMP_W-1:0]    dec_c;
    logic [RAMP_W-1:0]    rel_c;
    logic [SUM_W-1:0]     ramp_sum;
    logic                 long_note;
    logic [MS_W-1:0]      seg_ms;
    logic [STEPS_W-1:0]   seg_steps;
    logic [AMP_W-1:0]     seg_from;
    logic [AMP_W-1:0]     seg_to;
    logic                 seg_later;
    t_phase               ph_next;
    logic [NUM_W-1:0]     num_next;
    logic [RAMP_W-1:0]    third;
    logic [SUM_W-1:0]     two_third;
    logic                 last_step;

    adsr_ts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    adsr_ts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // clamp configuration to legal ranges
    always_comb begin
        vol_c     = (cfg.volume > PCT_MAX) ? PCT_MAX : cfg.volume;
        pct_c     = (cfg.sustain_pct > PCT_MAX) ? PCT_MAX : cfg.sustain_pct;
        att_c     = (cfg.attack_ms > RAMP_MAX) ? RAMP_MAX : cfg.attack_ms;
        dec_c     = (cfg.decay_ms > RAMP_MAX) ? RAMP_MAX : cfg.decay_ms;
        rel_c     = (cfg.release_ms > RAMP_MAX) ? RAMP_MAX : cfg.release_ms;
        ramp_sum  = SUM_W'(att_c) + SUM_W'(dec_c) + SUM_W'(rel_c);
        long_note = (r_len >= LEN_W'(ramp_sum));
    end

    // short-note split: thirds for attack and decay, rest for release
    always_comb begin
        third     = (div_rsp.quot[RAMP_W-1:0] == '0) ? RAMP_W'(1) : div_rsp.quot[RAMP_W-1:0];
        two_third = {1'b0, third, 1'b0};
    end

    // current segment: length, endpoints and whether commands follow it
    always_comb begin
        case (r_phase)
            PH_ATK: begin
                seg_ms    = r_a;
                seg_from  = '0;
                seg_to    = r_peak;
                seg_later = (r_d != '0) || (r_sus_ms != '0) || (r_r != '0);
                ph_next   = PH_DEC;
            end
            PH_DEC: begin
                seg_ms    = r_d;
                seg_from  = r_peak;
                seg_to    = r_sus;
                seg_later = (r_sus_ms != '0) || (r_r != '0);
                ph_next   = PH_SUS;
            end
            PH_SUS: begin
                seg_ms    = '0;
                seg_from  = r_sus;
                seg_to    = r_sus;
                seg_later = (r_r != '0);
                ph_next   = PH_REL;
            end
            PH_REL: begin
                seg_ms    = r_r;
                seg_from  = r_sus;
                seg_to    = '0;
                seg_later = 1'b0;
                ph_next   = PH_REL;
            end
            default: begin
                seg_ms    = '0;
                seg_from  = '0;
                seg_to    = '0;
                seg_later = 1'b0;
                ph_next   = PH_REL;
            end
        endcase
        seg_steps = (seg_ms[MS_W-1:STEP_SHIFT] == '0) ? STEPS_W'(1)
                                                      : STEPS_W'(seg_ms[MS_W-1:STEP_SHIFT]);
        num_next  = NUM_W'((({1'b0, r_num} + (NUM_W+1)'(seg_to)) - (NUM_W+1)'(seg_from)));
        last_step = (r_i == r_steps);
    end

    // divider requests
    always_comb begin
        div_req = '0;
        case (r_state)
            S_SUSQ: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'(DIV_NW'(r_peak) * DIV_NW'(pct_c));
                div_req.divisor  = DIV_PCT;
            end
            S_LEN: begin
                div_req.start    = !long_note;
                div_req.dividend = DIV_NW'(r_len);
                div_req.divisor  = DIV_THIRD;
            end
            S_SEG: begin
                div_req.start    = (r_phase != PH_SUS) && (seg_ms != '0);
                div_req.dividend = DIV_NW'(seg_ms);
                div_req.divisor  = DIV_DW'(seg_steps);
            end
            S_STEP: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'(num_next);
                div_req.divisor  = DIV_DW'(r_steps);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_ATK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_note.valid) begin
                        r_freq <= i_note.note_freq_hz;
                        r_len  <= i_note.note_len_ms;
                        if ((i_note.note_freq_hz != '0) && (i_note.note_len_ms != '0) &&
                            (vol_c != '0)) begin
                            r_state <= S_PEAK;
                        end
                    end
                end
                S_PEAK: begin
                    r_peak  <= AMP_BASE + AMP_SLOPE * AMP_W'(vol_c);
                    r_state <= S_SUSQ;
                end
                S_SUSQ: r_state <= S_SUSW;
                S_SUSW: begin
                    if (div_rsp.done) begin
                        r_sus   <= div_rsp.quot[AMP_W-1:0];
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_phase <= PH_ATK;
                    if (long_note) begin
                        r_a      <= MS_W'(att_c);
                        r_d      <= MS_W'(dec_c);
                        r_r      <= MS_W'(rel_c);
                        r_sus_ms <= r_len - LEN_W'(ramp_sum);
                        r_state  <= S_SEG;
                    end else begin
                        r_state <= S_THIRD;
                    end
                end
                S_THIRD: begin
                    if (div_rsp.done) begin
                        r_a      <= MS_W'(third);
                        r_d      <= MS_W'(third);
                        r_r      <= (r_len[SUM_W-1:0] > two_third)
                                    ? MS_W'(r_len[SUM_W-1:0] - two_third) : MS_W'(1);
                        r_sus_ms <= '0;
                        r_state  <= S_SEG;
                    end
                end
                S_SEG: begin
                    if (r_phase == PH_SUS) begin
                        if (r_sus_ms != '0) begin
                            r_out_len  <= r_sus_ms;
                            r_out_amp  <= r_sus;
                            r_out_last <= seg_later == 1'b0;
                            r_state    <= S_OUT;
                        end else begin
                            r_phase <= PH_REL;
                        end
                    end else if (seg_ms == '0) begin
                        if (r_phase == PH_REL) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_phase <= ph_next;
                        end
                    end else begin
                        r_steps <= seg_steps;
                        r_state <= S_DUR;
                    end
                end
                S_DUR: begin
                    if (div_rsp.done) begin
                        r_dur   <= div_rsp.quot[DUR_W-1:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // numerator before step one: from * steps
                    r_num   <= NUM_W'(NUM_W'(seg_from) * NUM_W'(r_steps));
                    r_i     <= STEPS_W'(1);
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_num   <= num_next;
                    r_state <= S_AMP;
                end
                S_AMP: begin
                    if (div_rsp.done) begin
                        r_out_amp  <= div_rsp.quot[AMP_W-1:0];
                        r_out_len  <= LEN_W'(r_dur);
                        r_out_last <= last_step && !seg_later;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_tone.ready) begin
                        if (r_phase == PH_SUS) begin
                            r_phase <= PH_REL;
                            r_state <= S_SEG;
                        end else if (last_step) begin
                            if (r_phase == PH_REL) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_phase <= ph_next;
                                r_state <= S_SEG;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_STEP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // channel outputs
    assign i_note.ready          = (r_state == S_IDLE);
    assign o_tone.valid          = (r_state == S_OUT);
    assign o_tone.tone_freq_hz   = r_freq;
    assign o_tone.tone_len_ms    = r_out_len;
    assign o_tone.tone_amplitude = r_out_amp;
    assign o_tone.last_of_note   = r_out_last;

    // checks
    a_one_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tone.valid |-> !i_note.ready)
        else $error("note request taken while a tone command is pending");

    a_amp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tone.valid |-> (o_tone.tone_amplitude <= AMP_MAX))
        else $error("tone amplitude above peak range");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tone.valid |-> (o_tone.tone_len_ms != '0))
        else $error("tone command of zero length");

    // after the last command only empty segments are skipped on the way to idle
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tone.valid && o_tone.ready && o_tone.last_of_note)
        |=> ((r_state == S_IDLE) || (r_state == S_SEG)))
        else $error("commands continue after last of note");

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_ts_div.sv =====
// ============================================================================
// adsr_ts_div: shared serial divider
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module adsr_ts_div
    import adsr_ts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_work;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;

    logic [DIV_DW:0]   trial;
    logic              qbit;
    logic [DIV_DW-1:0] rem_next;

    // one restoring step
    always_comb begin
        trial    = {r_rem, r_work[DIV_NW-1]};
        qbit     = (trial >= {1'b0, r_dvs});
        rem_next = qbit ? DIV_DW'(trial - {1'b0, r_dvs}) : DIV_DW'(trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_work <= {r_work[DIV_NW-2:0], qbit};
            r_rem  <= rem_next;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_work;

    // checks
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_nonzero_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_dvs != '0))
        else $error("divider running with zero divisor");

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_ts_regs.sv =====
// ============================================================================
// adsr_ts_regs: configuration registers
// APB-style register file for volume, ramp lengths and sustain level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module adsr_ts_regs
    import adsr_ts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume      <= VOL_RST;
            r_cfg.attack_ms   <= ATTACK_RST;
            r_cfg.decay_ms    <= DECAY_RST;
            r_cfg.sustain_pct <= SUSTAIN_RST;
            r_cfg.release_ms  <= RELEASE_RST;
        end else if (wr_en) begin
            case (idx)
                REG_VOLUME:  r_cfg.volume      <= pwdata[VOL_W-1:0];
                REG_ATTACK:  r_cfg.attack_ms   <= pwdata[RAMP_W-1:0];
                REG_DECAY:   r_cfg.decay_ms    <= pwdata[RAMP_W-1:0];
                REG_SUSTAIN: r_cfg.sustain_pct <= pwdata[PCT_W-1:0];
                REG_RELEASE: r_cfg.release_ms  <= pwdata[RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_VOLUME:  prdata = APB_DW'(r_cfg.volume);
            REG_ATTACK:  prdata = APB_DW'(r_cfg.attack_ms);
            REG_DECAY:   prdata = APB_DW'(r_cfg.decay_ms);
            REG_SUSTAIN: prdata = APB_DW'(r_cfg.sustain_pct);
            REG_RELEASE: prdata = APB_DW'(r_cfg.release_ms);
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire
